// File: rtl/slc_pkg.sv
// shared constants, types and helpers for the single-linkage clustering block
package slc_pkg;

    localparam int MAX_POINTS = 64;
    localparam int DIST_BITS  = 16;
    localparam int IDX_BITS   = $clog2(MAX_POINTS);
    localparam int CNT_BITS   = IDX_BITS + 1;
    localparam int ADDR_BITS  = 2 * IDX_BITS;
    localparam int MEM_DEPTH  = MAX_POINTS * MAX_POINTS;
    localparam logic [CNT_BITS-1:0] POINTS_RESET = CNT_BITS'(32);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_EMIT,
        ST_UPD_RDA,
        ST_UPD_RDB,
        ST_UPD_WR
    } slc_state_t;

    // lower-triangle address of an unordered pair
    function automatic logic [ADDR_BITS-1:0] pair_addr(
        input logic [IDX_BITS-1:0] a,
        input logic [IDX_BITS-1:0] b
    );
        logic [ADDR_BITS-1:0] res;
        if (a > b)
        begin
            res = {a, b};
        end
        else
        begin
            res = {b, a};
        end
        return res;
    endfunction

endpackage

// File: rtl/slc_ram.sv
// generic single-write single-read ram with registered read data
module slc_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// File: rtl/single_linkage_clustering.sv
// top level: streamed distance-matrix load and single-linkage merge sequencer
//
// Matrix entries are taken one per cycle while the block is idle; the entry
// marked last_entry starts a clustering run on points 0 .. n-1, with n the
// configured point count clamped to 2 .. MAX_POINTS, and input is stalled
// until the row update after the run's last merge has finished. Each round
// scans every lower-triangle pair once through the single read port of the
// distance ram, one pair per cycle, then a drain state and an emit state that
// waits for the output register to be free; the row update that follows
// reads both distances of each other live point, writes back the smaller and
// skips retired or merged slots. A run of n points yields n-1 merges.
module single_linkage_clustering
    import slc_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_write,
    input  logic [CNT_BITS-1:0]  cfg_data,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [IDX_BITS-1:0]  row_index,
    input  logic [IDX_BITS-1:0]  col_index,
    input  logic [DIST_BITS-1:0] distance_value,
    input  logic                 last_entry,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [IDX_BITS-1:0]  cluster_low,
    output logic [IDX_BITS-1:0]  cluster_high,
    output logic [DIST_BITS-1:0] merge_distance,
    output logic                 last_merge
);

    slc_state_t state_reg, state_next;

    logic [CNT_BITS-1:0]   points_reg;
    logic [CNT_BITS-1:0]   n_reg, n_next;
    logic [MAX_POINTS-1:0] active_reg, active_next;
    logic [IDX_BITS-1:0]   k_reg, k_next;
    logic [IDX_BITS-1:0]   r_reg, r_next;
    logic [IDX_BITS-1:0]   c_reg, c_next;
    logic [IDX_BITS-1:0]   v_reg, v_next;
    logic                  s1_vld_reg, s1_vld_next;
    logic [IDX_BITS-1:0]   s1_r_reg, s1_c_reg;
    logic                  found_reg, found_next;
    logic [DIST_BITS-1:0]  best_reg, best_next;
    logic [IDX_BITS-1:0]   br_reg, br_next;
    logic [IDX_BITS-1:0]   bc_reg, bc_next;
    logic [DIST_BITS-1:0]  a_reg, a_next;

    logic                  out_valid_reg, out_valid_next;
    logic [IDX_BITS-1:0]   low_reg, low_next;
    logic [IDX_BITS-1:0]   high_reg, high_next;
    logic [DIST_BITS-1:0]  dist_reg, dist_next;
    logic                  lastm_reg, lastm_next;

    logic                  wr_en;
    logic [ADDR_BITS-1:0]  wr_addr;
    logic [DIST_BITS-1:0]  wr_data;
    logic [ADDR_BITS-1:0]  rd_addr;
    logic [DIST_BITS-1:0]  rd_data;

    logic                  in_acc;
    logic [CNT_BITS-1:0]   n_clamped;
    logic [IDX_BITS-1:0]   n_last;
    logic                  slot_free;

    slc_ram #(
        .WIDTH (DIST_BITS),
        .DEPTH (MEM_DEPTH)
    ) u_dist_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign in_stall  = (state_reg != ST_IDLE);
    assign in_acc    = in_valid && !in_stall;
    assign slot_free = !out_valid_reg || !out_stall;
    assign n_last    = IDX_BITS'(n_reg - CNT_BITS'(1));

    always_comb
    begin
        if (points_reg < CNT_BITS'(2))
        begin
            n_clamped = CNT_BITS'(2);
        end
        else if (points_reg > CNT_BITS'(MAX_POINTS))
        begin
            n_clamped = CNT_BITS'(MAX_POINTS);
        end
        else
        begin
            n_clamped = points_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            points_reg    <= POINTS_RESET;
            active_reg    <= '0;
            k_reg         <= '0;
            s1_vld_reg    <= 1'b0;
            found_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            active_reg    <= active_next;
            k_reg         <= k_next;
            s1_vld_reg    <= s1_vld_next;
            found_reg     <= found_next;
            out_valid_reg <= out_valid_next;
            if (cfg_write)
            begin
                points_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg     <= n_next;
        r_reg     <= r_next;
        c_reg     <= c_next;
        v_reg     <= v_next;
        s1_r_reg  <= r_reg;
        s1_c_reg  <= c_reg;
        best_reg  <= best_next;
        br_reg    <= br_next;
        bc_reg    <= bc_next;
        a_reg     <= a_next;
        low_reg   <= low_next;
        high_reg  <= high_next;
        dist_reg  <= dist_next;
        lastm_reg <= lastm_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        n_next         = n_reg;
        active_next    = active_reg;
        k_next         = k_reg;
        r_next         = r_reg;
        c_next         = c_reg;
        v_next         = v_reg;
        s1_vld_next    = 1'b0;
        found_next     = found_reg;
        best_next      = best_reg;
        br_next        = br_reg;
        bc_next        = bc_reg;
        a_next         = a_reg;
        out_valid_next = out_valid_reg && out_stall;
        low_next       = low_reg;
        high_next      = high_reg;
        dist_next      = dist_reg;
        lastm_next     = lastm_reg;
        wr_en          = 1'b0;
        wr_addr        = {row_index, col_index};
        wr_data        = distance_value;
        rd_addr        = {r_reg, c_reg};

        // compare stage, fed by the scan read issued in the previous cycle
        if (s1_vld_reg && (!found_reg || rd_data < best_reg))
        begin
            found_next = 1'b1;
            best_next  = rd_data;
            br_next    = s1_r_reg;
            bc_next    = s1_c_reg;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    wr_en = (row_index > col_index);
                    if (last_entry)
                    begin
                        n_next = n_clamped;
                        for (int i = 0; i < MAX_POINTS; i++)
                        begin
                            active_next[i] = (CNT_BITS'(i) < n_clamped);
                        end
                        k_next     = '0;
                        r_next     = IDX_BITS'(1);
                        c_next     = '0;
                        found_next = 1'b0;
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_SCAN:
            begin
                s1_vld_next = active_reg[r_reg] && active_reg[c_reg];
                if (c_reg == IDX_BITS'(r_reg - IDX_BITS'(1)))
                begin
                    c_next = '0;
                    r_next = IDX_BITS'(r_reg + IDX_BITS'(1));
                    if (r_reg == n_last)
                    begin
                        state_next = ST_DRAIN;
                    end
                end
                else
                begin
                    c_next = IDX_BITS'(c_reg + IDX_BITS'(1));
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    low_next       = bc_reg;
                    high_next      = br_reg;
                    dist_next      = best_reg;
                    lastm_next     = (CNT_BITS'(k_reg) + CNT_BITS'(2) == n_reg);
                    v_next         = '0;
                    state_next     = ST_UPD_RDA;
                end
            end
            ST_UPD_RDA:
            begin
                rd_addr = pair_addr(bc_reg, v_reg);
                if (!active_reg[v_reg] || v_reg == bc_reg || v_reg == br_reg)
                begin
                    if (v_reg == n_last)
                    begin
                        active_next[br_reg] = 1'b0;
                        k_next              = IDX_BITS'(k_reg + IDX_BITS'(1));
                        r_next              = IDX_BITS'(1);
                        c_next              = '0;
                        found_next          = 1'b0;
                        if (CNT_BITS'(k_reg) + CNT_BITS'(2) == n_reg)
                        begin
                            state_next = ST_IDLE;
                        end
                        else
                        begin
                            state_next = ST_SCAN;
                        end
                    end
                    else
                    begin
                        v_next = IDX_BITS'(v_reg + IDX_BITS'(1));
                    end
                end
                else
                begin
                    state_next = ST_UPD_RDB;
                end
            end
            ST_UPD_RDB:
            begin
                rd_addr    = pair_addr(br_reg, v_reg);
                a_next     = rd_data;
                state_next = ST_UPD_WR;
            end
            ST_UPD_WR:
            begin
                wr_en   = 1'b1;
                wr_addr = pair_addr(bc_reg, v_reg);
                wr_data = (a_reg < rd_data) ? a_reg : rd_data;
                if (v_reg == n_last)
                begin
                    active_next[br_reg] = 1'b0;
                    k_next              = IDX_BITS'(k_reg + IDX_BITS'(1));
                    r_next              = IDX_BITS'(1);
                    c_next              = '0;
                    found_next          = 1'b0;
                    if (CNT_BITS'(k_reg) + CNT_BITS'(2) == n_reg)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        state_next = ST_SCAN;
                    end
                end
                else
                begin
                    v_next     = IDX_BITS'(v_reg + IDX_BITS'(1));
                    state_next = ST_UPD_RDA;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign out_valid      = out_valid_reg;
    assign cluster_low    = low_reg;
    assign cluster_high   = high_reg;
    assign merge_distance = dist_reg;
    assign last_merge     = lastm_reg;

    // merged pair is always ordered low then high
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (cluster_low < cluster_high))
    else $error("merged pair out of order");

    // both slots of the chosen pair are still live when the merge is emitted
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT) |-> (active_reg[bc_reg] && active_reg[br_reg] && found_reg))
    else $error("merge chosen on a retired slot");

    // the row update only ever writes the surviving slot's distances
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_UPD_WR) |-> (v_reg != bc_reg && v_reg != br_reg))
    else $error("row update hit a merged slot");

endmodule
